[src/oqrbv_pkg.sv]
// ----------------------------------------------------------------------------
// oqrbv_pkg - ordered queue shared definitions
// Depth, widths, opcode and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package oqrbv_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int VAL_W       = 32;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_DRAIN  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic       append;
        logic       remove;
        logic       pop;
        logic       load;
        logic       sel_head;
        logic [1:0] status;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
        logic found;
    } t_stat;

endpackage

[src/oqrbv_if.sv]
// ----------------------------------------------------------------------------
// oqrbv_in_if / oqrbv_out_if - valid/ready channels of the ordered queue
// Input words carry an opcode and a value; output words a value and status.
// ----------------------------------------------------------------------------
interface oqrbv_in_if;
    import oqrbv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] item_value;

    modport source (output valid, output opcode, output item_value, input ready);
    modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface oqrbv_out_if;
    import oqrbv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_value;
    logic [1:0]              status;
    logic                    last;

    modport source (output valid, output out_value, output status, output last, input ready);
    modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

[src/oqrbv_ctrl.sv]
// ----------------------------------------------------------------------------
// oqrbv_ctrl - ordered queue controller
// Decodes input words, sequences the drain and owns the output valid flag.
// ----------------------------------------------------------------------------
module oqrbv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  oqrbv_pkg::t_stat  i_stat,
    output oqrbv_pkg::t_cmd   o_cmd
);
    import oqrbv_pkg::*;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic accept;
    t_cmd cmd;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_APPEND: begin
                            cmd.append = !i_stat.full;
                            cmd.load   = 1'b1;
                            cmd.status = i_stat.full ? ST_FULL : ST_OK;
                            cmd.last   = 1'b1;
                        end
                        OP_REMOVE: begin
                            cmd.remove = !i_stat.empty && i_stat.found;
                            cmd.load   = 1'b1;
                            cmd.last   = 1'b1;
                            if (i_stat.empty) begin
                                cmd.status = ST_EMPTY;
                            end else if (!i_stat.found) begin
                                cmd.status = ST_NOT_FOUND;
                            end else begin
                                cmd.status = ST_OK;
                            end
                        end
                        OP_DRAIN: begin
                            if (i_stat.empty) begin
                                cmd.load   = 1'b1;
                                cmd.status = ST_EMPTY;
                                cmd.last   = 1'b1;
                            end else begin
                                n_state = S_DRAIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    cmd.pop      = 1'b1;
                    cmd.load     = 1'b1;
                    cmd.sel_head = 1'b1;
                    cmd.status   = ST_OK;
                    cmd.last     = i_stat.one;
                    if (i_stat.one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

[src/oqrbv_dp.sv]
// ----------------------------------------------------------------------------
// oqrbv_dp - ordered queue datapath
// Entry cells with per-entry compare, gap closing shift, count, output word.
// ----------------------------------------------------------------------------
module oqrbv_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [oqrbv_pkg::VAL_W-1:0] i_item_value,
    input  oqrbv_pkg::t_cmd                    i_cmd,
    output oqrbv_pkg::t_stat                   o_stat,
    output logic signed [oqrbv_pkg::VAL_W-1:0] o_out_value,
    output logic [1:0]                         o_status,
    output logic                               o_last
);
    import oqrbv_pkg::*;

    logic signed [VAL_W-1:0] r_store [QUEUE_DEPTH];
    logic [CNT_W-1:0]        r_count, n_count;
    logic [QUEUE_DEPTH-1:0]  match;
    logic [QUEUE_DEPTH-1:0]  shift;
    logic signed [VAL_W-1:0] r_out_value;
    logic [1:0]              r_status;
    logic                    r_last;

    // compare cells, then mark every entry at or behind the first match
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            match[i] = (CNT_W'(i) < r_count) && (r_store[i] == i_item_value);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            shift[i] = |(match & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.one   = (r_count == CNT_W'(1));
    assign o_stat.found = |match;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.append && (r_count[IDX_W-1:0] == IDX_W'(i))) begin
                r_store[i] <= i_item_value;
            end else if (((i_cmd.remove && shift[i]) || i_cmd.pop) && (i < QUEUE_DEPTH - 1)) begin
                r_store[i] <= r_store[(i + 1) % QUEUE_DEPTH];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.append) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.remove || i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_value <= i_cmd.sel_head ? r_store[0] : '0;
            r_status    <= i_cmd.status;
            r_last      <= i_cmd.last;
        end
    end

    assign o_out_value = r_out_value;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

[src/ordered_queue_remove_by_value.sv]
// ----------------------------------------------------------------------------
// ordered_queue_remove_by_value - bounded ordered queue with delete by value
// Input words on i_in: opcode (append, remove first match, drain) and a value.
// Output words on o_out: value, status and a last flag on the final word of
// each input word.
// Append and remove give one status word each; the input word's result sits
// in the output register in the cycle after it is taken. The compare cells
// find the first match and close the gap as the word is taken.
// A drain gives one word per held entry, one per cycle while o_out is not
// stalled, head first, popping the head cell each time; no input is taken
// until the final entry leaves. An empty drain gives a single empty status
// word. Opcode three is taken and gives nothing.
// Sustained rate: one input word per cycle for append and remove while o_out
// is not stalled; a drain takes no new input word until it is through.
// Reset empties the queue and clears the output valid flag; entry contents
// are not cleared. While o_out is stalled the output word holds and a new
// input word is taken only in the cycle that the held word is taken.
// ----------------------------------------------------------------------------
module ordered_queue_remove_by_value (
    input  logic  i_clk,
    input  logic  i_rst_n,
    oqrbv_in_if.sink    i_in,
    oqrbv_out_if.source o_out
);
    import oqrbv_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    oqrbv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_opcode    (i_in.opcode),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    oqrbv_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_value (i_in.item_value),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_value  (o_out.out_value),
        .o_status     (o_out.status),
        .o_last       (o_out.last)
    );

endmodule
